[rtl/lra_pkg.sv]
`default_nettype none

package lra_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MODE       = 2'd0,
    REG_COLOR_LOW  = 2'd1,
    REG_COLOR_HIGH = 2'd2,
    REG_BRIGHTNESS = 2'd3
  } reg_idx_e;

  localparam logic        MODE_SPINNER = 1'b0;
  localparam logic        MODE_PULSE   = 1'b1;

  localparam logic [4:0]  STEP_TOP     = 5'd24;
  localparam logic [5:0]  STEP_WEIGHT  = 6'd41;
  localparam logic [9:0]  WEIGHT_FULL  = 10'd1000;
  localparam logic [6:0]  PERCENT_FULL = 7'd100;

  // floor(x/1000) = (x*RECIP_1000) >> SHIFT_1000, exact for x <= 255000
  localparam logic [18:0] RECIP_1000 = 19'd268436;
  localparam int          SHIFT_1000 = 28;
  // floor(x/100) = (x*RECIP_100) >> SHIFT_100, exact for x <= 25500
  localparam logic [15:0] RECIP_100  = 16'd41944;
  localparam int          SHIFT_100  = 22;

  localparam logic        RST_MODE       = MODE_SPINNER;
  localparam logic [23:0] RST_COLOR_LOW  = 24'h0000FF;
  localparam logic [23:0] RST_COLOR_HIGH = 24'h00FFFF;
  localparam logic [6:0]  RST_BRIGHTNESS = 7'd100;

  typedef struct packed {
    logic start;      // request accepted: clear pixel counter
    logic tick;       // advance animation
    logic blend_sum;  // weighted sum of both colors
    logic blend_div;  // divide sum by 1000
    logic scale_mul;  // channel times brightness
    logic scale_div;  // divide by 100
    logic load;       // load next pixel into output register
  } cmd_t;

  typedef struct packed {
    logic out_free;   // output register can take a pixel
    logic last;       // pixel counter at final pixel
  } status_t;

endpackage

`default_nettype wire

[rtl/lra_ctrl.sv]
`default_nettype none

module lra_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [0:0]      advance_i,
  output logic                 in_stall_o,
  input  wire lra_pkg::status_t st_i,
  output lra_pkg::cmd_t        cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLEND,
    ST_BLEND_DIV,
    ST_SCALE,
    ST_SCALE_DIV,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = (state_q == ST_IDLE) && in_valid_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.start     = accept;
    cmd_o.tick      = accept && advance_i[0];
    cmd_o.blend_sum = (state_q == ST_BLEND);
    cmd_o.blend_div = (state_q == ST_BLEND_DIV);
    cmd_o.scale_mul = (state_q == ST_SCALE);
    cmd_o.scale_div = (state_q == ST_SCALE_DIV);
    cmd_o.load      = (state_q == ST_EMIT) && st_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (accept) state_d = ST_BLEND;
      ST_BLEND:     state_d = ST_BLEND_DIV;
      ST_BLEND_DIV: state_d = ST_SCALE;
      ST_SCALE:     state_d = ST_SCALE_DIV;
      ST_SCALE_DIV: state_d = ST_EMIT;
      ST_EMIT:      if (st_i.out_free && st_i.last) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_load_outside_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == ST_EMIT)
    else $error("pixel load outside emit phase");

  a_emit_follows_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCALE_DIV |=> state_q == ST_EMIT)
    else $error("scale phase not followed by emit");

  a_accept_starts_blend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_BLEND && in_stall_o)
    else $error("accepted request did not start a frame");

endmodule

`default_nettype wire

[rtl/lra_datapath.sv]
`default_nettype none

module lra_datapath #(
  parameter int PIXELS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [23:0]      cfg_data_i,
  input  wire lra_pkg::cmd_t    cmd_i,
  output lra_pkg::status_t      st_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [3:0]            pixel_index_o,
  output logic [7:0]            red_o,
  output logic [7:0]            green_o,
  output logic [7:0]            blue_o,
  output logic                  last_pixel_o
);

  localparam int COUNT = (PIXELS < 16) ? PIXELS : 16;
  localparam int PW    = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int CW    = (PW > 4) ? PW : 4;
  localparam logic [3:0] LAST_IDX = 4'(COUNT - 1);

  // configuration
  logic                  mode_q;
  logic [2:0][7:0]       color_low_q, color_high_q;
  logic [6:0]            brightness_q;

  // animation state
  logic [4:0]            step_q;
  logic                  rising_q;
  logic [PW-1:0]         pos_q;      // step modulo PIXELS

  // frame pipeline
  logic [2:0][17:0]      sum_q;
  logic [2:0][7:0]       blend_q;
  logic [2:0][14:0]      fg_mul_q, bg_mul_q;
  logic [2:0][7:0]       fg_q, bg_q;
  logic [3:0]            pix_q;

  // output register
  logic                  out_valid_q;
  logic [3:0]            pix_out_q;
  logic [2:0][7:0]       rgb_out_q;
  logic                  last_out_q;

  // combinational helpers
  logic [4:0]            step_d;
  logic                  wrap;
  logic [PW:0]           pos_inc;
  logic [PW-1:0]         pos_next, pos1;
  logic [10:0]           raw_w;
  logic [9:0]            w_clamp, w;
  logic [6:0]            bright;
  logic [2:0][7:0]       fg_src;
  logic [2:0][17:0]      sum_d;
  logic [2:0][7:0]       blend_d, fg_d, bg_d;
  logic [2:0][14:0]      fg_mul_d, bg_mul_d;
  logic [CW-1:0]         pix_ext;
  logic                  lit;

  assign wrap     = (step_q > lra_pkg::STEP_TOP - 5'd1);
  assign step_d   = wrap ? 5'd0 : step_q + 5'd1;
  assign pos_inc  = {1'b0, pos_q} + (PW+1)'(1);
  assign pos_next = (pos_inc == (PW+1)'(PIXELS)) ? '0 : pos_inc[PW-1:0];
  assign pos1     = pos_next;

  assign raw_w   = 11'(step_q) * 11'(lra_pkg::STEP_WEIGHT);
  assign w_clamp = (raw_w > 11'(lra_pkg::WEIGHT_FULL)) ? lra_pkg::WEIGHT_FULL : raw_w[9:0];
  assign w       = rising_q ? w_clamp : lra_pkg::WEIGHT_FULL - w_clamp;
  assign bright  = (brightness_q > lra_pkg::PERCENT_FULL) ? lra_pkg::PERCENT_FULL
                                                          : brightness_q;
  assign fg_src  = (mode_q == lra_pkg::MODE_PULSE) ? blend_q : color_high_q;

  always_comb begin
    logic [36:0] bprod;
    logic [30:0] fprod, gprod;
    bprod = '0;
    fprod = '0;
    gprod = '0;
    for (int ch = 0; ch < 3; ch++) begin
      sum_d[ch]    = 18'(color_low_q[ch]) * 18'(lra_pkg::WEIGHT_FULL - w)
                   + 18'(color_high_q[ch]) * 18'(w);
      bprod        = 37'(sum_q[ch]) * 37'(lra_pkg::RECIP_1000);
      blend_d[ch]  = bprod[lra_pkg::SHIFT_1000 +: 8];
      fg_mul_d[ch] = 15'(fg_src[ch]) * 15'(bright);
      bg_mul_d[ch] = 15'(color_low_q[ch]) * 15'(bright);
      fprod        = 31'(fg_mul_q[ch]) * 31'(lra_pkg::RECIP_100);
      gprod        = 31'(bg_mul_q[ch]) * 31'(lra_pkg::RECIP_100);
      fg_d[ch]     = fprod[lra_pkg::SHIFT_100 +: 8];
      bg_d[ch]     = gprod[lra_pkg::SHIFT_100 +: 8];
    end
  end

  // spinner lights the pixels at step and step+1 modulo PIXELS
  assign pix_ext = CW'(pix_q);
  assign lit     = (mode_q == lra_pkg::MODE_PULSE)
                || (pix_ext == CW'(pos_q)) || (pix_ext == CW'(pos1));

  assign st_o.out_free = !out_valid_q || !out_stall_i;
  assign st_o.last     = (pix_q == LAST_IDX);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= lra_pkg::RST_MODE;
      color_low_q  <= lra_pkg::RST_COLOR_LOW;
      color_high_q <= lra_pkg::RST_COLOR_HIGH;
      brightness_q <= lra_pkg::RST_BRIGHTNESS;
    end else if (cfg_valid_i) begin
      unique case (lra_pkg::reg_idx_e'(cfg_index_i))
        lra_pkg::REG_MODE:       mode_q       <= cfg_data_i[0];
        lra_pkg::REG_COLOR_LOW:  color_low_q  <= cfg_data_i;
        lra_pkg::REG_COLOR_HIGH: color_high_q <= cfg_data_i;
        lra_pkg::REG_BRIGHTNESS: brightness_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // animation state and control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 5'd0;
      rising_q    <= 1'b1;
      pos_q       <= '0;
      pix_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.tick) begin
        step_q <= step_d;
        pos_q  <= wrap ? '0 : pos_next;
        if (step_d == 5'd0) rising_q <= !rising_q;
      end
      if (cmd_i.start) begin
        pix_q <= 4'd0;
      end else if (cmd_i.load) begin
        pix_q <= pix_q + 4'd1;
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // frame payload pipeline
  always_ff @(posedge clk_i) begin
    if (cmd_i.blend_sum) sum_q   <= sum_d;
    if (cmd_i.blend_div) blend_q <= blend_d;
    if (cmd_i.scale_mul) begin
      fg_mul_q <= fg_mul_d;
      bg_mul_q <= bg_mul_d;
    end
    if (cmd_i.scale_div) begin
      fg_q <= fg_d;
      bg_q <= bg_d;
    end
    if (cmd_i.load) begin
      pix_out_q  <= pix_q;
      rgb_out_q  <= lit ? fg_q : bg_q;
      last_out_q <= (pix_q == LAST_IDX);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = pix_out_q;
  assign red_o         = rgb_out_q[2];
  assign green_o       = rgb_out_q[1];
  assign blue_o        = rgb_out_q[0];
  assign last_pixel_o  = last_out_q;

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= lra_pkg::STEP_TOP)
    else $error("animation step out of range");

  a_pos_tracks_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < PW'(PIXELS - 1) || pos_q == PW'(PIXELS - 1))
    else $error("spinner position out of range");

  a_flip_on_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tick && step_q == lra_pkg::STEP_TOP |=> rising_q != $past(rising_q))
    else $error("direction did not flip on wrap");

  a_pix_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> pix_q <= LAST_IDX)
    else $error("pixel counter beyond frame");

endmodule

`default_nettype wire

[rtl/led_ring_animation_frames_top.sv]
// LED ring animation frame generator.
// Input channel (in_valid_i / in_stall_o, payload advance_i): one request
// per tick. advance_i=1 steps the animation (step 0..24, direction flips
// on wrap) then emits a frame; advance_i=0 re-emits the current frame.
// Output channel (out_valid_o / out_stall_i): one item per ring pixel,
// pixel_index 0 first, last_pixel_o set on the final one; at most 16.
// Config channel (cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i):
// 0 mode, 1 color_low, 2 color_high, 3 brightness. Always ready; write
// only while no frame is in flight.
// Setup: after the request the frame passes blend sum, divide by 1000,
// brightness multiply and divide by 100; then one pixel per cycle comes
// out of the output register while the output does not stall.
// The next request is taken as soon as the last pixel is loaded, even
// while that pixel still waits in the output register.
// Stall on the output simply holds the pixel sequencer; nothing is lost.
// Reset: mode spinner, colors 0x0000FF/0x00FFFF, brightness 100, step 0,
// direction rising, output empty.
`default_nettype none

module led_ring_animation_frames_top #(
  parameter int PIXELS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [0:0]  advance_i,
  // pixel channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       pixel_index_o,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic             last_pixel_o,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);

  lra_pkg::cmd_t    cmd;
  lra_pkg::status_t st;

  assign cfg_ready_o = 1'b1;

  // sequencer: idle, setup phases, pixel emission
  lra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .advance_i  (advance_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // config, animation state, color arithmetic and output register
  lra_datapath #(
    .PIXELS (PIXELS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .st_o          (st),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_index_o (pixel_index_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule

`default_nettype wire
